[hdl/rmlo_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the radial motion block.
package rmlo_pkg;

    localparam int COORD_W   = 32;
    localparam int MAG_W     = COORD_W + 1;
    localparam int UNIT_BITS = 30;
    localparam int UNIT_W    = UNIT_BITS + 1;
    localparam int CAP_W     = 34;
    localparam int SUM_W     = 36;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int IN_W      = 7 * COORD_W;
    localparam int OUT_W     = 3 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP  = 1'd1;

    localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_SQRT,
        ST_DIV,
        ST_PROD,
        ST_OFFS,
        ST_FIN
    } t_state;

endpackage

[hdl/radial_motion_from_latched_origin.sv]
`timescale 1ns / 1ps
// Top level: radial push of a position away from an origin latched on the first item.
// Usage
//   Input channel s_axis carries one update: start position, target point and
//   elapsed time. The first transaction after reset latches the start position
//   as the origin; later start fields are ignored. Output channel m_axis carries
//   origin + unit(target - origin) * time * speed, saturated per coordinate,
//   with the saturation flag in tuser. The user writes the configuration (speed,
//   keep_origin_height) only with nothing in flight; the block does not enforce it.
// Operation
//   One update at a time through a shared 32x32 multiplier and a shared 64-bit
//   compare-subtract unit. After an update is accepted, the core runs the
//   one-bit/eight-bit normalising shifts, the sum of squares, the root steps,
//   the division steps of each of the three components, time x speed, the
//   three offsets and the hand-over. A zero-length direction skips the sum of
//   squares, the root and the division. s_axis_tready is high only in idle, so
//   the next transaction is taken in the cycle after the hand-over at the earliest.
// Reset and stall
//   Reset clears the origin latch, speed returns to 1.0 and the mode bit to 0.
//   A finished result waits in the output register while the core takes the next
//   update; a second result holds in the hand-over state until the first is taken.
module radial_motion_from_latched_origin
    import rmlo_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_wdata,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x, start_y, start_z, target_x, target_y, target_z, time_since_start
    input  logic [IN_W-1:0]      s_axis_tdata,
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_x, out_y, out_z
    output logic [OUT_W-1:0]     m_axis_tdata,
    // clipped
    output logic [0:0]           m_axis_tuser
);

    localparam int SHR = FRAC_BITS + UNIT_BITS - 32;
    localparam logic [63:0] CAP = 64'd1 << 33;

    // Control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_awaiting;
    logic                  r_ovalid;
    logic [COORD_W-1:0]    r_speed;
    logic                  r_keep;

    // Datapath
    logic [COORD_W-1:0]    r_org [3];
    logic [MAG_W-1:0]      r_mag [3];
    logic                  r_neg [3];
    logic [UNIT_W-1:0]     r_u   [3];
    logic [COORD_W-1:0]    r_rx  [3];
    logic [COORD_W-1:0]    r_time;
    logic [61:0]           r_s;
    logic [62:0]           r_res;
    logic [62:0]           r_bit;
    logic [30:0]           r_rem;
    logic [30:0]           r_low;
    logic [30:0]           r_q;
    logic [63:0]           r_mp;
    logic [63:0]           r_prod;
    logic [63:0]           r_hi;
    logic [CAP_W-1:0]      r_t;
    logic                  r_clip;
    logic [OUT_W-1:0]      r_out;
    logic                  r_out_clip;

    // Shared unit operands
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           sub_a, sub_b;
    logic [64:0]           sub_d;
    logic                  sub_ge;

    logic                  in_acc;
    logic                  out_free;
    logic [COORD_W-1:0]    o_sel [3];
    logic [MAG_W-1:0]      in_mag [3];
    logic                  in_neg [3];
    logic                  all_zero, need_right, need_left, left8;
    logic [63:0]           trial;
    logic [31:0]           rem2;
    logic                  spd_neg;
    logic [COORD_W-1:0]    spd_mag;
    logic [63:0]           top;
    logic [63:0]           t_full;
    logic [CAP_W-1:0]      t_cap;
    logic signed [SUM_W-1:0] o_ext, t_ext, pos_sum;
    logic                  sat_hi, sat_lo;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    assign spd_neg = r_speed[COORD_W-1];
    assign spd_mag = spd_neg ? (~r_speed + 32'd1) : r_speed;

    // Direction from origin to target; the origin comes from the item itself
    // on the first transaction.
    always_comb begin
        logic signed [MAG_W-1:0] d;
        for (int k = 0; k < 3; k++) begin
            o_sel[k] = r_awaiting ? s_axis_tdata[k*COORD_W +: COORD_W] : r_org[k];
            d = $signed({s_axis_tdata[(k+3)*COORD_W + COORD_W-1],
                         s_axis_tdata[(k+3)*COORD_W +: COORD_W]})
                - $signed({o_sel[k][COORD_W-1], o_sel[k]});
            if (k == 2 && r_keep) begin
                d = '0;
            end
            in_neg[k] = d[MAG_W-1];
            in_mag[k] = in_neg[k] ? MAG_W'(-d) : MAG_W'(d);
        end
    end

    // Normalising shift decisions: largest magnitude into [2^29, 2^30)
    always_comb begin
        all_zero   = ~|{r_mag[0], r_mag[1], r_mag[2]};
        need_right = |{r_mag[0][32:30], r_mag[1][32:30], r_mag[2][32:30]};
        need_left  = ~|{r_mag[0][32:29], r_mag[1][32:29], r_mag[2][32:29]};
        left8      = ~|{r_mag[0][32:21], r_mag[1][32:21], r_mag[2][32:21]};
    end

    // Shared compare-subtract unit
    assign trial  = {1'b0, r_res} + {1'b0, r_bit};
    assign rem2   = {r_rem, r_low[30]};
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[64];

    // Offset magnitude and saturating sum for the current component
    always_comb begin
        top     = r_hi + {32'b0, r_mp[63:32]};
        t_full  = top >> SHR;
        t_cap   = (t_full > CAP) ? CAP_W'(CAP) : t_full[CAP_W-1:0];
        o_ext   = SUM_W'($signed(r_org[r_idx]));
        t_ext   = $signed({{(SUM_W-CAP_W){1'b0}}, r_t});
        pos_sum = (r_neg[r_idx] != spd_neg) ? (o_ext - t_ext) : (o_ext + t_ext);
        sat_hi  = pos_sum > $signed(SUM_W'($signed(SAT_MAX)));
        sat_lo  = pos_sum < $signed(SUM_W'($signed(SAT_MIN)));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_NORM;
            ST_NORM: begin
                if (all_zero) begin
                    n_state = ST_PROD;
                end else if (!need_right && !need_left) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR:  if (r_cnt == CNT_W'(3)) n_state = ST_SQRT;
            ST_SQRT: if (r_cnt == CNT_W'(31)) n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_W'(31) && r_idx == IDX_W'(2)) n_state = ST_PROD;
            ST_PROD: if (r_cnt == CNT_W'(1)) n_state = ST_OFFS;
            ST_OFFS: if (r_cnt == CNT_W'(3) && r_idx == IDX_W'(2)) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Step and component counters
    always_comb begin
        n_cnt = r_cnt + CNT_W'(1);
        n_idx = r_idx;
        if (r_state != n_state) begin
            n_cnt = '0;
            n_idx = '0;
        end else if (r_state == ST_DIV && r_cnt == CNT_W'(31)) begin
            n_cnt = '0;
            n_idx = r_idx + IDX_W'(1);
        end else if (r_state == ST_OFFS && r_cnt == CNT_W'(3)) begin
            n_cnt = '0;
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // Outputs of the sequencer: handshake and shared unit operands
    always_comb begin
        s_axis_tready = 1'b0;
        mul_a = '0;
        mul_b = '0;
        sub_a = '0;
        sub_b = '0;
        unique case (r_state)
            // Hold off transactions while reset is applied
            ST_IDLE: s_axis_tready = i_rst_n;
            ST_SQR: begin
                unique case (r_cnt[1:0])
                    2'd0:    mul_a = r_mag[0][31:0];
                    2'd1:    mul_a = r_mag[1][31:0];
                    2'd2:    mul_a = r_mag[2][31:0];
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            ST_SQRT: begin
                sub_a = {2'b0, r_s};
                sub_b = trial;
            end
            ST_DIV: begin
                sub_a = {32'b0, rem2};
                sub_b = {33'b0, r_res[30:0]};
            end
            ST_PROD: begin
                mul_a = r_time;
                mul_b = spd_mag;
            end
            ST_OFFS: begin
                mul_a = (r_cnt == '0) ? r_prod[63:32] : r_prod[31:0];
                mul_b = {1'b0, r_u[r_idx]};
            end
            ST_NORM, ST_FIN: ;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_awaiting <= 1'b1;
            r_ovalid   <= 1'b0;
            r_speed    <= COORD_W'(64'd1 << FRAC_BITS);
            r_keep     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            if (in_acc) begin
                r_awaiting <= 1'b0;
            end
            if (r_state == ST_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wen) begin
                unique case (i_cfg_idx)
                    REG_SPEED: r_speed <= i_cfg_wdata;
                    REG_KEEP:  r_keep  <= i_cfg_wdata[0];
                    default:   ;
                endcase
            end
        end
    end

    // Shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_mp <= {32'b0, mul_a} * {32'b0, mul_b};
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    for (int k = 0; k < 3; k++) begin
                        r_org[k] <= o_sel[k];
                        r_mag[k] <= in_mag[k];
                        r_neg[k] <= in_neg[k];
                    end
                    r_time <= s_axis_tdata[6*COORD_W +: COORD_W];
                    r_clip <= 1'b0;
                end
            end
            ST_NORM: begin
                if (all_zero) begin
                    // Zero-length direction: aim straight up
                    r_u[0] <= '0;
                    r_u[1] <= '0;
                    r_u[2] <= UNIT_W'(1) << UNIT_BITS;
                    for (int k = 0; k < 3; k++) r_neg[k] <= 1'b0;
                end else if (need_right) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] >> 1;
                end else if (left8) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 8;
                end else if (need_left) begin
                    for (int k = 0; k < 3; k++) r_mag[k] <= r_mag[k] << 1;
                end else begin
                    r_s <= '0;
                end
            end
            ST_SQR: begin
                if (r_cnt != '0) begin
                    r_s <= r_s + r_mp[61:0];
                end
                r_res <= '0;
                r_bit <= 63'd1 << 62;
            end
            ST_SQRT: begin
                // One bit of the integer square root per step
                if (sub_ge) begin
                    r_s   <= sub_d[61:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    r_rem <= {2'b0, r_mag[r_idx][29:1]};
                    r_low <= {r_mag[r_idx][0], 30'b0};
                end else begin
                    // One quotient bit per step against the length
                    r_rem <= sub_ge ? sub_d[30:0] : rem2[30:0];
                    r_low <= r_low << 1;
                    r_q   <= {r_q[29:0], sub_ge};
                    if (r_cnt == CNT_W'(31)) begin
                        r_u[r_idx] <= {r_q[29:0], sub_ge};
                    end
                end
            end
            ST_PROD: begin
                if (r_cnt == CNT_W'(1)) begin
                    r_prod <= r_mp;
                end
            end
            ST_OFFS: begin
                unique case (r_cnt[1:0])
                    2'd1: r_hi <= r_mp;
                    2'd2: r_t  <= t_cap;
                    2'd3: begin
                        if (sat_hi) begin
                            r_rx[r_idx] <= SAT_MAX;
                        end else if (sat_lo) begin
                            r_rx[r_idx] <= SAT_MIN;
                        end else begin
                            r_rx[r_idx] <= pos_sum[COORD_W-1:0];
                        end
                        r_clip <= r_clip | sat_hi | sat_lo;
                    end
                    default: ;
                endcase
            end
            ST_FIN: begin
                if (out_free) begin
                    r_out      <= {r_rx[2], r_rx[1], r_rx[0]};
                    r_out_clip <= r_clip;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_clip;

endmodule

[hdl/rmlo_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the radial motion block and their binding.
module rmlo_checker
    import rmlo_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [0:0]       m_axis_tuser
);

    logic [COORD_W-1:0] x, y, z;
    assign x = m_axis_tdata[0*COORD_W +: COORD_W];
    assign y = m_axis_tdata[1*COORD_W +: COORD_W];
    assign z = m_axis_tdata[2*COORD_W +: COORD_W];

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed or dropped");

    // Not ready again in the cycle after each transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again straight after a transaction");

    // Nothing offered straight out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // Clip flag only with a coordinate at a rail
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (x == SAT_MAX || x == SAT_MIN || y == SAT_MAX || y == SAT_MIN
             || z == SAT_MAX || z == SAT_MIN))
        else $error("clip flag without a saturated coordinate");

endmodule

bind radial_motion_from_latched_origin rmlo_checker u_rmlo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the radial motion block: directed and random updates against a predictor.
module testbench;
    import rmlo_pkg::*;

    localparam int FRAC          = 16;
    localparam int UNIT_SHIFT    = 30;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_UPDATES = 116;
    localparam int MAX_REPORTS   = 100;

    // Origin latched by the very first transaction; x and y sit at the two ends of the range
    // so that directions of full 33-bit magnitude can be reached.
    localparam logic [COORD_W-1:0] ORG_X = 32'h8000_0000;
    localparam logic [COORD_W-1:0] ORG_Y = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] ORG_Z = 32'h0001_8000;
    localparam logic [COORD_W-1:0] ONE   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

    // One input transaction; start[0] sits in the lowest bits, as on s_axis_tdata.
    typedef struct packed {
        logic [COORD_W-1:0]        elapsed;
        logic [2:0][COORD_W-1:0]   target;
        logic [2:0][COORD_W-1:0]   start;
    } t_update;

    // One output transaction: {m_axis_tuser, m_axis_tdata}.
    typedef struct packed {
        logic                      clipped;
        logic [2:0][COORD_W-1:0]   pos;
    } t_motion;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_SPEED;
    logic [COORD_W-1:0]   i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [0:0]           m_axis_tuser;

    // Predictor state: configuration and the latched origin
    logic [COORD_W-1:0]      cfg_speed;
    logic                    cfg_keep_height;
    logic                    awaiting_origin;
    logic [2:0][COORD_W-1:0] origin;

    t_motion expected_moves[$];
    int      mismatches = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      stall_left = 0;

    radial_motion_from_latched_origin #(
        .FRAC_BITS(FRAC)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    // Work out the position the block must produce for one update. Latch the origin on the
    // first transaction, aim from it to the target, normalise to a unit vector with 30 fraction
    // bits and push the origin out along it by elapsed * speed, saturating each coordinate.
    function automatic t_motion predict_motion(input logic [2:0][COORD_W-1:0] start,
                                               input logic [2:0][COORD_W-1:0] target,
                                               input logic [COORD_W-1:0] elapsed);
        logic signed [63:0] o[3];
        logic signed [63:0] d[3];
        logic signed [63:0] r;
        logic signed [63:0] spd;
        logic [63:0]        mag[3];
        logic [63:0]        unit[3];
        logic [63:0]        m, sq, rem, root, bitv, spd_mag, prod, t;
        logic [127:0]       wide;
        logic               neg[3];
        logic               spd_neg;
        t_motion            res;

        if (awaiting_origin) begin
            origin = start;
            awaiting_origin = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            o[i] = $signed(origin[i]);
            d[i] = $signed(target[i]) - o[i];
        end
        if (cfg_keep_height)
            d[2] = 0;

        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = d[i] < 0;
            mag[i] = neg[i] ? -d[i] : d[i];
            if (mag[i] > m)
                m = mag[i];
        end

        if (m == 0) begin
            // Zero-length direction: aim straight up
            unit[0] = 0;
            unit[1] = 0;
            unit[2] = 64'd1 << UNIT_SHIFT;
            neg[0] = 1'b0;
            neg[1] = 1'b0;
            neg[2] = 1'b0;
        end else begin
            // Bring the largest magnitude into [2^29, 2^30); right shifts truncate
            while (m >= (64'd1 << 30)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
            end
            while (m < (64'd1 << 29)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            // Floor square root, two radicand bits per step
            rem = sq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            for (int i = 0; i < 3; i++)
                unit[i] = (mag[i] << UNIT_SHIFT) / root;
        end

        spd = $signed(cfg_speed);
        spd_neg = spd < 0;
        spd_mag = spd_neg ? -spd : spd;
        prod = {32'd0, elapsed} * spd_mag;

        res.clipped = 1'b0;
        for (int i = 0; i < 3; i++) begin
            wide = {64'd0, prod} * {64'd0, unit[i]};
            wide = wide >> (FRAC + UNIT_SHIFT);
            t = wide[63:0];
            if (t > (64'd1 << 33))
                t = 64'd1 << 33;
            r = (neg[i] != spd_neg) ? o[i] - $signed(t) : o[i] + $signed(t);
            if (r > $signed(SAT_MAX)) begin
                r = $signed(SAT_MAX);
                res.clipped = 1'b1;
            end else if (r < $signed(SAT_MIN)) begin
                r = $signed(SAT_MIN);
                res.clipped = 1'b1;
            end
            res.pos[i] = r[COORD_W-1:0];
        end
        return res;
    endfunction

    // Drive the receiver: short and occasional long stalls so that a finished result can sit
    // in the output register while the next one waits in the hand-over state.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            stall_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(1, 400)
                                                      : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every output transaction with the oldest pending prediction
    always @(posedge i_clk) begin : check_results
        t_motion want;
        t_motion got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (expected_moves.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = expected_moves.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got.pos[i] !== want.pos[i])
                        report_mismatch($sformatf("coordinate %0d: got %h, want %h",
                                                  i, got.pos[i], want.pos[i]));
                if (got.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped: got %b, want %b",
                                              got.clipped, want.clipped));
            end
        end
    end

    task automatic set_idling(input t_idling mode);
        send_idle_pct  = (mode == IDLE_SENDER) ? 70 : (mode == IDLE_BOTH) ? 17 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 70 : (mode == IDLE_BOTH) ? 17 : 0;
    endtask

    // Offer one update and hold it until the block takes it. Gaps reach past the block's
    // latency now and then, so they land on every stage of its work.
    task automatic send_update(input logic [2:0][COORD_W-1:0] start,
                               input logic [2:0][COORD_W-1:0] target,
                               input logic [COORD_W-1:0] elapsed);
        t_update u;
        int      gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 250) : $urandom_range(1, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        u.start   = start;
        u.target  = target;
        u.elapsed = elapsed;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= u;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_moves.push_back(predict_motion(start, target, elapsed));
    endtask

    // Drop valid and hold until every pending result has come out
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_moves.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges; only call while the block is idle
    task automatic write_settings(input logic [COORD_W-1:0] speed, input logic keep_height);
        i_cfg_wen   <= 1'b1;
        i_cfg_idx   <= REG_SPEED;
        i_cfg_wdata <= speed;
        @(posedge i_clk);
        i_cfg_idx   <= REG_KEEP;
        i_cfg_wdata <= {31'd0, keep_height};
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        cfg_speed       = speed;
        cfg_keep_height = keep_height;
        @(posedge i_clk);
    endtask

    function automatic t_update random_update();
        t_update            u;
        logic signed [31:0] delta;
        for (int i = 0; i < 3; i++) begin
            u.start[i] = $urandom();
            case ($urandom_range(0, 7))
                0: u.target[i] = origin[i];
                1: u.target[i] = $urandom_range(0, 1) ? C_MAX : C_MIN;
                2, 3: begin
                    // Near the origin: exercises the normalising left shifts
                    delta = $signed($urandom()) >>> $urandom_range(0, 31);
                    u.target[i] = origin[i] + delta;
                end
                default: u.target[i] = $urandom();
            endcase
        end
        if ($urandom_range(0, 19) == 0)
            u.target = origin;
        case ($urandom_range(0, 5))
            0: u.elapsed = $urandom();
            1: u.elapsed = $urandom_range(0, 1) ? C_MAX | C_MIN : '0;
            default: u.elapsed = $urandom() >> $urandom_range(0, 31);
        endcase
        return u;
    endfunction

    // First transaction latches the origin; later start fields must have no effect
    task automatic test_origin_latch();
        set_idling(IDLE_NONE);
        send_update({ORG_Z, ORG_Y, ORG_X}, {ORG_Z, 32'd0, ONE}, ONE);
        send_update('1, {ORG_Z, ORG_Y, ORG_X}, 32'h0002_0000);
        send_update('0, {ORG_Z, ORG_Y, ORG_X}, '1);
        send_update({C_MAX, C_MIN, C_MAX}, {ORG_Z, ORG_Y, ORG_X}, 32'h0000_0001);
    endtask

    // Longest and shortest directions and elapsed extremes
    task automatic test_direction_extremes();
        set_idling(IDLE_NONE);
        send_update('0, {C_MAX, C_MIN, C_MAX}, '1);
        send_update('0, {C_MIN, ORG_Y, ORG_X}, ONE);
        send_update('0, {ORG_Z, ORG_Y, ORG_X + 32'd1}, ONE);
        send_update('0, {ORG_Z + 32'd1, ORG_Y - 32'd1, ORG_X + 32'd1}, 32'h0003_0000);
        send_update('0, '0, '0);
        send_update('0, {C_MIN, C_MIN, C_MAX}, 32'h0000_0001);
        send_update('0, {32'h0001_0000, C_MAX, C_MIN}, 32'h8000_0000);
    endtask

    // Speed at its extremes, negative speed and the keep-height mode
    task automatic test_register_extremes();
        logic [COORD_W-1:0] speed;
        set_idling(IDLE_NONE);
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: speed = C_MAX;
                1: speed = C_MIN;
                2: speed = '0;
                default: speed = 32'hFFFF_0000;
            endcase
            wait_for_drain();
            write_settings(speed, k[0]);
            send_update('0, {C_MAX, C_MIN, C_MAX}, '1);
            // Zero-length direction when the height is kept
            send_update('0, {$urandom(), ORG_Y, ORG_X}, 32'h0004_8000);
            send_update('0, {ORG_Z - 32'h0010_0000, ORG_Y - 32'h0003_0000, ORG_X + 32'h0005_0000},
                        ONE);
        end
    endtask

    // Random updates through every idling pattern, with and without the height kept
    task automatic test_random_traffic();
        logic [COORD_W-1:0] speed;
        t_update            u;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: speed = ONE;
                2: speed = C_MAX;
                3: speed = C_MIN;
                5: speed = '0;
                1, 6: begin
                    speed = $urandom_range(0, 32'h0004_0000);
                    if ($urandom_range(0, 1))
                        speed = -speed;
                end
                default: speed = $urandom();
            endcase
            wait_for_drain();
            write_settings(speed, p >= RANDOM_PHASES / 2);
            set_idling(t_idling'(p % 4));
            repeat (PHASE_UPDATES) begin
                u = random_update();
                send_update(u.start, u.target, u.elapsed);
            end
        end
    endtask

    initial begin
        cfg_speed       = ONE;
        cfg_keep_height = 1'b0;
        awaiting_origin = 1'b1;
        origin          = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_origin_latch();
        test_direction_extremes();
        test_register_extremes();
        test_random_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_moves.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
